@@ hdl/wsfd_pkg.sv @@
// Package for the WebSocket frame deframer.
// Holds the parse phase encoding and the header field constants; no dependencies.
package wsfd_pkg;

  localparam int unsigned LengthBitsDefault = 64;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes = 4'd4;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

endpackage

@@ hdl/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer: one stream byte in per cycle while the output is not stalled, unmasked payload bytes out.
// A payload byte is registered and appears on the output in the cycle after its input transfer.
// Bytes flow at one per cycle unless the output stalls; the output register is refilled in the cycle it drains.
// Header and key bytes give no output; a zero-length frame gives one marker transfer.
// Reset (rst_ni, async, active low): parser waits for the first header byte, output empty.
// Depends on wsfd_pkg.
module websocket_frame_deframer_top #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] payload_byte
  output logic [5:0] m_axis_tuser_o,   // [3:0] frame_opcode, [4] final_fragment, [5] empty_frame
  output logic       m_axis_tlast_o    // last_of_frame
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic                   fin_q, fin_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_q, mask_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;     // length, then bytes remaining
  logic [31:0]            key_q, key_d;
  logic [1:0]             idx_q, idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic [5:0] out_user_q;
  logic       out_last_q;

  logic       accept;
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_empty;
  logic [7:0] b;
  logic [3:0] cnt_dec;
  logic [7:0] key_byte;
  logic       len_zero;

  assign b        = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_dec  = cnt_q - 4'd1;
  assign len_zero = (len_q == '0);

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    key_d     = key_q;
    idx_d     = idx_q;
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    unique case (phase_q)
      wsfd_pkg::PH_HDR1: begin
        mask_d = b[7];
        key_d  = '0;
        if (b[6:0] == wsfd_pkg::Len7Ext16 || b[6:0] == wsfd_pkg::Len7Ext64) begin
          len_d   = '0;
          cnt_d   = (b[6:0] == wsfd_pkg::Len7Ext16) ? wsfd_pkg::ExtBytes16
                                                    : wsfd_pkg::ExtBytes64;
          phase_d = wsfd_pkg::PH_EXTLEN;
        end else begin
          len_d = LENGTH_BITS'(b[6:0]);
          idx_d = 2'd0;
          if (b[7]) begin
            cnt_d   = wsfd_pkg::KeyBytes;
            phase_d = wsfd_pkg::PH_KEY;
          end else if (b[6:0] == 7'd0) begin
            cnt_d     = 4'd0;
            phase_d   = wsfd_pkg::PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            cnt_d   = 4'd0;
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        if (len_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
          len_d = '1;
        end else begin
          len_d = {len_q[LENGTH_BITS-9:0], b};
        end
        cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          idx_d = 2'd0;
          if (mask_q) begin
            cnt_d   = wsfd_pkg::KeyBytes;
            phase_d = wsfd_pkg::PH_KEY;
          end else if (len_d == '0) begin
            phase_d   = wsfd_pkg::PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_KEY: begin
        key_d = {key_q[23:0], b};
        cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (len_zero) begin
            phase_d   = wsfd_pkg::PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_byte  = mask_q ? (b ^ key_byte) : b;
        res_last  = (len_q == LENGTH_BITS'(1));
        len_d     = len_q - LENGTH_BITS'(1);
        idx_d     = idx_q + 2'd1;
        if (res_last) begin
          phase_d = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        fin_d    = b[7];
        opcode_d = b[3:0];
        cnt_d    = 4'd0;
        phase_d  = wsfd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsfd_pkg::PH_HDR0;
      cnt_q       <= 4'd0;
      fin_q       <= 1'b0;
      opcode_q    <= 4'd0;
      mask_q      <= 1'b0;
      len_q       <= '0;
      key_q       <= '0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        fin_q    <= fin_d;
        opcode_q <= opcode_d;
        mask_q   <= mask_d;
        len_q    <= len_d;
        key_q    <= key_d;
        idx_q    <= idx_d;
      end
    end
  end

  // result payload, loaded with the transfer that produces it
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_byte_q <= res_byte;
      out_user_q <= {res_empty, fin_q, opcode_q};
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
